FILE: rtl/bms_pkg.sv
package bms_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int REG_BYTES  = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_LEN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_MLO = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_MHI = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI  = 3'd4;

	typedef struct packed {
		logic start_build;
		logic build_step;
		logic accept;
		logic load;
		logic cmp_step;
		logic finish;
	} bms_cmd_t;

	typedef struct packed {
		logic tables_ready;
		logic build_done;
		logic need_search;
		logic cmp_done;
		logic last_pending;
		logic out_free;
	} bms_status_t;

endpackage

FILE: rtl/boyer_moore_search.sv
// Boyer-Moore first-occurrence search over a byte stream.
// Config port: cfg_we/cfg_index/cfg_data write pattern_len (0) and the four
// 64-bit pattern byte registers (1..4), byte 0 in the low bits. Write only
// while no text is in flight.
// Input stream s_*: one text byte per request, s_tlast on the final byte.
// Output stream m_*: one request per text, after the byte with s_tlast:
// found and the offset of the leftmost match (0 if none, saturating).
// Before the first byte of a text the pattern is latched and the good-suffix
// table built, one shift per cycle, pattern length capped at MAX_PATTERN;
// no input is accepted meanwhile. Each byte is then accepted in idle; one
// that completes an alignment is followed by a window RAM load and backward
// compares that read the RAM one byte a cycle; no byte is accepted until
// they end. m_tvalid is set by the finish state, after the last compare or
// the last byte's request if it needs none. The result sits in an output
// register; a stalled m_tready holds it and the block still accepts input
// until the next result must be written. Reset clears the control state and
// the per-text counters; the tables, window and compare registers need no
// clearing since they are written before use.
module boyer_moore_search #(
	parameter int MAX_PATTERN  = 32,
	parameter int WINDOW_DEPTH = 64,
	parameter int OFFSET_BITS  = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bms_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bms_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,   // text_byte
	input  logic                                s_tlast,   // last
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [((OFFSET_BITS+8)/8)*8-1:0]    m_tdata    // found, match_offset
);
	import bms_pkg::*;

	localparam int OUT_W = ((OFFSET_BITS + 8) / 8) * 8;

	bms_cmd_t              cmd;
	bms_status_t           status;
	logic                  found;
	logic [OFFSET_BITS-1:0] offset;

	bms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	bms_datapath #(
		.MAX_PATTERN  (MAX_PATTERN),
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.OFFSET_BITS  (OFFSET_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.text_byte  (s_tdata),
		.text_last  (s_tlast),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_found  (found),
		.out_offset (offset),
		.cmd        (cmd),
		.status     (status)
	);

	assign m_tdata = OUT_W'({offset, found});

endmodule

FILE: rtl/bms_ctrl.sv
module bms_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tlast,
	output logic                 s_tready,
	input  bms_pkg::bms_status_t status,
	output bms_pkg::bms_cmd_t    cmd
);
	import bms_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_BUILD = 3'd1;
	localparam logic [2:0] ST_LOAD  = 3'd2;
	localparam logic [2:0] ST_CMP   = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign s_tready = (state_q == ST_IDLE) && status.tables_ready;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid && status.tables_ready) begin
					cmd.accept = 1'b1;
					if (status.need_search) state_d = ST_LOAD;
					else if (s_tlast) state_d = ST_FIN;
				end else if (s_tvalid) begin
					cmd.start_build = 1'b1;
					state_d = ST_BUILD;
				end
			end
			ST_BUILD: begin
				cmd.build_step = 1'b1;
				if (status.build_done) state_d = ST_IDLE;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				cmd.cmp_step = 1'b1;
				if (status.cmp_done) state_d = status.last_pending ? ST_FIN : ST_IDLE;
			end
			ST_FIN: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule

FILE: rtl/bms_datapath.sv
module bms_datapath #(
	parameter int MAX_PATTERN  = 32,
	parameter int WINDOW_DEPTH = 64,
	parameter int OFFSET_BITS  = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bms_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bms_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [7:0]                     text_byte,
	input  logic                           text_last,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic                           out_found,
	output logic [OFFSET_BITS-1:0]         out_offset,
	input  bms_pkg::bms_cmd_t              cmd,
	output bms_pkg::bms_status_t           status
);
	import bms_pkg::*;

	localparam int N_W   = $clog2(MAX_PATTERN + 1);
	localparam int PI_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int GS_W  = (MAX_PATTERN > 1) ? $clog2(2 * MAX_PATTERN) : 1;
	localparam int WA_W  = $clog2(WINDOW_DEPTH);
	localparam int CNT_W = OFFSET_BITS + 1;
	localparam logic [WA_W-1:0] WA_LAST = WA_W'(WINDOW_DEPTH - 1);
	localparam logic [CNT_W-1:0] OFF_MAX = {1'b0, {OFFSET_BITS{1'b1}}};

	// configuration registers
	logic [5:0]            len_q;
	logic [CFG_DATA_W-1:0] preg_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			for (int i = 0; i < 4; i++) preg_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LEN:     len_q <= cfg_data[5:0];
				CFG_PAT_LO:  preg_q[0] <= cfg_data;
				CFG_PAT_MLO: preg_q[1] <= cfg_data;
				CFG_PAT_MHI: preg_q[2] <= cfg_data;
				CFG_PAT_HI:  preg_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// pattern and length to latch for the current text
	logic [N_W-1:0] n_new;
	logic [7:0]     pnew [MAX_PATTERN];
	assign n_new = ({26'd0, len_q} > MAX_PATTERN) ? N_W'(MAX_PATTERN) : N_W'(len_q);

	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (i < REG_BYTES && i < n_new) pnew[i] = preg_q[i / 8][(i % 8) * 8 +: 8];
			else pnew[i] = 8'd0;
		end
	end

	logic [7:0]             p_q   [MAX_PATTERN];
	logic [7:0]             sp_q  [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] spv_q;
	logic [MAX_PATTERN-1:0] done_q;
	logic [GS_W-1:0]        gs_q  [MAX_PATTERN];
	logic [N_W-1:0]         n_q;
	logic [N_W-1:0]         s_q;
	logic                   tables_ready_q;

	// good-suffix build: one shift s per cycle, all positions j at once
	logic [MAX_PATTERN-1:0] m_vec;
	logic [MAX_PATTERN-1:0] ok_vec;
	logic [MAX_PATTERN-1:0] low_mask;

	always_comb begin
		for (int k = 0; k < MAX_PATTERN; k++)
			m_vec[k] = !(k < n_q && spv_q[k]) || (sp_q[k] == p_q[k]);
		for (int j = 0; j < MAX_PATTERN; j++) begin
			low_mask = '0;
			for (int k = 0; k < MAX_PATTERN; k++) low_mask[k] = (k <= j);
			ok_vec[j] = (j < n_q) && (&(m_vec | low_mask))
				&& !(spv_q[j] && sp_q[j] == p_q[j]);
		end
	end

	assign status.build_done   = (s_q >= n_q);
	assign status.tables_ready = tables_ready_q;

	// per-text search state
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] align_q;
	logic [CNT_W-1:0] t_q;
	logic [CNT_W-1:0] mpos_q;
	logic             seen_q;
	logic             last_q;
	logic [PI_W-1:0]  j_q;
	logic [WA_W-1:0]  wp_q;
	logic [WA_W-1:0]  r_q;
	logic [WA_W-1:0]  r_prev;
	logic [WA_W-1:0]  raddr;
	logic [7:0]       rdata_q;
	logic [7:0]       win_mem [WINDOW_DEPTH];

	assign r_prev = (r_q == '0) ? WA_LAST : r_q - 1'b1;
	assign raddr  = cmd.load ? r_q : r_prev;

	always_ff @(posedge clk) begin
		if (cmd.accept) win_mem[wp_q] <= text_byte;
		rdata_q <= win_mem[raddr];
	end

	// bad-character shift of the mismatching byte, from the pattern itself
	logic [N_W-1:0]   bc;
	logic [GS_W-1:0]  gs_j;
	logic [CNT_W-1:0] skip;
	logic             eq;

	always_comb begin
		bc = n_q;
		for (int i = 0; i < MAX_PATTERN; i++)
			if ((i + 1) < n_q && p_q[i] == rdata_q) bc = N_W'(n_q - N_W'(i) - 1'b1);
	end

	assign gs_j = gs_q[j_q];
	assign eq   = (rdata_q == p_q[j_q]);
	assign skip = (CNT_W'(bc) > CNT_W'(gs_j)) ? CNT_W'(bc) : CNT_W'(gs_j);

	assign status.need_search  = !seen_q && (n_q != '0) && (align_q == cnt_q);
	assign status.cmp_done     = !eq || (j_q == '0);
	assign status.last_pending = last_q;
	assign status.out_free     = !out_valid || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.start_build) begin
			for (int i = 0; i < MAX_PATTERN; i++) begin
				p_q[i]  <= pnew[i];
				sp_q[i] <= (i >= 1) ? pnew[i - 1] : 8'd0;
			end
		end else if (cmd.build_step) begin
			for (int i = 0; i < MAX_PATTERN; i++) sp_q[i] <= (i >= 1) ? sp_q[i - 1] : 8'd0;
		end
		if (cmd.build_step) begin
			for (int j = 0; j < MAX_PATTERN; j++)
				if (!done_q[j] && (status.build_done || ok_vec[j]))
					gs_q[j] <= GS_W'(s_q) + GS_W'(n_q) - GS_W'(j) - 1'b1;
		end
		if (cmd.accept) begin
			r_q    <= wp_q;
			t_q    <= cnt_q;
			j_q    <= PI_W'(n_q - 1'b1);
			last_q <= text_last;
		end else if (cmd.cmp_step && eq) begin
			r_q <= r_prev;
			j_q <= j_q - 1'b1;
			if (j_q != '0) t_q <= t_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q            <= '0;
			s_q            <= '0;
			spv_q          <= '0;
			done_q         <= '0;
			tables_ready_q <= 1'b0;
			cnt_q          <= '0;
			align_q        <= '0;
			mpos_q         <= '0;
			seen_q         <= 1'b0;
			wp_q           <= '0;
			out_valid      <= 1'b0;
			out_found      <= 1'b0;
			out_offset     <= '0;
		end else begin
			if (out_valid && out_ready && !cmd.finish) out_valid <= 1'b0;
			if (cmd.start_build) begin
				n_q    <= n_new;
				s_q    <= N_W'(1);
				spv_q  <= {{(MAX_PATTERN-1){1'b1}}, 1'b0};
				done_q <= '0;
			end else if (cmd.build_step) begin
				if (status.build_done) begin
					tables_ready_q <= 1'b1;
					align_q <= (n_q != '0) ? CNT_W'(n_q - 1'b1) : '0;
					if (n_q == '0) begin
						seen_q <= 1'b1;
						mpos_q <= '0;
					end
				end else begin
					s_q    <= s_q + 1'b1;
					spv_q  <= {spv_q[MAX_PATTERN-2 >= 0 ? MAX_PATTERN-2 : 0:0], 1'b0};
					done_q <= done_q | ok_vec;
				end
			end
			if (cmd.accept) begin
				if (cnt_q != '1) cnt_q <= cnt_q + 1'b1;
				wp_q <= (wp_q == WA_LAST) ? '0 : wp_q + 1'b1;
			end
			if (cmd.cmp_step) begin
				if (eq && j_q == '0) begin
					seen_q <= 1'b1;
					mpos_q <= t_q;
				end else if (!eq) begin
					align_q <= t_q + skip;
				end
			end
			if (cmd.finish) begin
				out_valid  <= 1'b1;
				out_found  <= seen_q;
				out_offset <= !seen_q ? '0 : (mpos_q > OFF_MAX) ? '1 : mpos_q[OFFSET_BITS-1:0];
				cnt_q          <= '0;
				align_q        <= '0;
				mpos_q         <= '0;
				seen_q         <= 1'b0;
				tables_ready_q <= 1'b0;
				wp_q           <= '0;
			end
		end
	end

endmodule
